>>> sv/gtes_pkg.sv
package gtes_pkg;

  localparam int EVENT_SLOTS_DEF = 16;

  localparam logic [3:0] AD_DESC    = 4'he;
  localparam logic [6:0] REG_SIGNAL = 7'h60;
  localparam logic [6:0] REG_LABEL  = 7'h62;
  localparam logic [4:0] NREG_MAX   = 5'd16;
  localparam logic [1:0] PATH3      = 2'd2;

  localparam logic [1:0] FMT_PACKED  = 2'd0;
  localparam logic [1:0] FMT_REGLIST = 2'd1;

  localparam logic ITEM_EVENT  = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_STATUS
  } state_t;

endpackage

>>> sv/gtes_in_if.sv
interface gtes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] qword_low;
  logic [63:0] qword_high;
  logic [1:0]  source_path;
  logic        path3_masked;

  modport source (output valid, qword_low, qword_high, source_path, path3_masked,
                  input ready);
  modport sink (input valid, qword_low, qword_high, source_path, path3_masked,
                output ready);
endinterface

>>> sv/gtes_out_if.sv
interface gtes_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [1:0]  event_type;
  logic [63:0] event_data;
  logic        was_tag;
  logic        packet_end;
  logic        in_payload;
  logic        last;

  modport source (output valid, item_kind, event_type, event_data, was_tag, packet_end,
                  in_payload, last, input ready);
  modport sink (input valid, item_kind, event_type, event_data, was_tag, packet_end,
                in_payload, last, output ready);
endinterface

>>> sv/gtes_ram.sv
module gtes_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/gif_tag_event_scanner_top.sv
// Graphics-interface tag scanner: takes one 128-bit qword per word on in_if, decodes tags and
// tracks the payload, and buffers SIGNAL, FINISH and LABEL writes found in A+D descriptors of
// packed packets in an event RAM of EVENT_SLOTS entries. Each accepted qword, while cfg_wdata
// has set scanning on, gives zero or more event words and then one status word (last set) on
// out_if; with scanning off qwords are taken and ignored. Qwords that release no events stream
// at one per cycle while out_if is ready. A qword that releases buffered events (packet end or
// buffer full) holds the input off until they and the status word are loaded: each event is
// read back from the event RAM, whose registered read port needs a READ state ahead of each
// EMIT state, and the status word follows in a STATUS state of its own. Events of a masked
// path 3 packet are discarded at no cost. The output word is registered, and a qword is only
// taken while that register is empty or its word leaves in the same cycle, so a stalled out_if
// also stalls in_if.
module gif_tag_event_scanner_top #(
  parameter int EVENT_SLOTS = gtes_pkg::EVENT_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  gtes_in_if.sink       in_if,
  gtes_out_if.source    out_if
);

  localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CW = $clog2(EVENT_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS = CW'(EVENT_SLOTS);

  // control state
  gtes_pkg::state_t state_r, state_nxt;
  logic          scan_en_r;
  logic          expect_payload_r, expect_payload_nxt;
  logic [19:0]   payload_left_r, payload_left_nxt;
  logic [1:0]    packet_format_r, packet_format_nxt;
  logic [4:0]    register_count_r, register_count_nxt;
  logic [63:0]   descriptor_list_r, descriptor_list_nxt;
  logic [3:0]    descriptor_index_r, descriptor_index_nxt;
  logic          packet_scannable_r, packet_scannable_nxt;
  logic [1:0]    packet_path_r, packet_path_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] fc_r;
  logic [CW-1:0] rd_idx_r;
  logic          was_tag_r, ended_r;

  // output register
  logic          out_valid_r;
  logic          out_kind_r;
  logic [1:0]    out_type_r;
  logic [63:0]   out_data_r;
  logic          out_tag_r, out_end_r, out_pay_r, out_last_r;

  logic          out_free;
  logic          in_acc;
  logic          step;
  logic          load_status_now, load_status_reg, load_event;

  // step datapath
  logic          is_tag;
  logic [14:0]   nloop;
  logic [4:0]    nregs;
  logic [19:0]   prod;
  logic [20:0]   half_sum;
  logic [19:0]   plen;
  logic          has_ad;
  logic [3:0]    desc;
  logic [4:0]    idx_inc;
  logic [6:0]    reg_addr;
  logic          ev_wr;
  logic [1:0]    ev_kind;
  logic [CW-1:0] h1;
  logic          full, pend, flush, drop;
  logic [CW-1:0] emit_cnt;
  logic          ended_nxt;

  logic [65:0]   rd_data;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_acc   = in_if.valid && in_if.ready;
  assign step     = in_acc && scan_en_r;

  always_comb begin
    is_tag   = !expect_payload_r;
    nloop    = in_if.qword_low[14:0];
    nregs    = (in_if.qword_low[63:60] == 4'd0) ? gtes_pkg::NREG_MAX
                                                : {1'b0, in_if.qword_low[63:60]};
    prod     = {5'd0, nloop} * {15'd0, nregs};
    half_sum = ({1'b0, prod} + 21'd1) >> 1;
    unique case (in_if.qword_low[59:58])
      gtes_pkg::FMT_PACKED:  plen = prod;
      gtes_pkg::FMT_REGLIST: plen = half_sum[19:0];
      default:               plen = {5'd0, nloop};
    endcase
    has_ad = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if ((5'(i) < nregs) && (in_if.qword_high[i*4 +: 4] == gtes_pkg::AD_DESC)) begin
        has_ad = 1'b1;
      end
    end

    desc     = descriptor_list_r[descriptor_index_r*4 +: 4];
    idx_inc  = {1'b0, descriptor_index_r} + 5'd1;
    reg_addr = in_if.qword_high[6:0];
    ev_kind  = 2'(reg_addr - gtes_pkg::REG_SIGNAL);
    ev_wr    = !is_tag && packet_scannable_r && (desc == gtes_pkg::AD_DESC)
               && (reg_addr >= gtes_pkg::REG_SIGNAL) && (reg_addr <= gtes_pkg::REG_LABEL)
               && (held_r < SLOTS);

    expect_payload_nxt   = expect_payload_r;
    payload_left_nxt     = payload_left_r;
    packet_format_nxt    = packet_format_r;
    register_count_nxt   = register_count_r;
    descriptor_list_nxt  = descriptor_list_r;
    descriptor_index_nxt = descriptor_index_r;
    packet_scannable_nxt = packet_scannable_r;
    packet_path_nxt      = packet_path_r;
    pend                 = 1'b0;

    if (is_tag) begin
      packet_format_nxt    = in_if.qword_low[59:58];
      register_count_nxt   = nregs;
      descriptor_list_nxt  = in_if.qword_high;
      descriptor_index_nxt = 4'd0;
      packet_path_nxt      = in_if.source_path;
      payload_left_nxt     = plen;
      packet_scannable_nxt = (in_if.qword_low[59:58] == gtes_pkg::FMT_PACKED) && has_ad;
      expect_payload_nxt   = (plen != 20'd0);
      pend                 = (plen == 20'd0);
    end else begin
      if (packet_scannable_r) begin
        descriptor_index_nxt = (idx_inc == register_count_r) ? 4'd0 : idx_inc[3:0];
      end
      if (payload_left_r != 20'd0) begin
        payload_left_nxt = payload_left_r - 20'd1;
      end
      if (payload_left_nxt == 20'd0) begin
        expect_payload_nxt = 1'b0;
        pend               = 1'b1;
      end
    end

    h1        = held_r + CW'(ev_wr);
    full      = (h1 >= SLOTS);
    flush     = pend || full;
    drop      = (packet_path_nxt == gtes_pkg::PATH3) && in_if.path3_masked;
    emit_cnt  = (flush && !drop) ? h1 : '0;
    held_nxt  = flush ? '0 : h1;
    ended_nxt = pend;
  end

  // fsm outputs
  always_comb begin
    in_if.ready     = 1'b0;
    load_status_now = 1'b0;
    load_status_reg = 1'b0;
    load_event      = 1'b0;
    unique case (state_r)
      gtes_pkg::ST_IDLE: begin
        in_if.ready     = out_free;
        load_status_now = step && (emit_cnt == '0);
      end
      gtes_pkg::ST_READ: begin
      end
      gtes_pkg::ST_EMIT: begin
        load_event = out_free;
      end
      gtes_pkg::ST_STATUS: begin
        load_status_reg = out_free;
      end
      default: begin
      end
    endcase
  end

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gtes_pkg::ST_IDLE: begin
        if (step && (emit_cnt != '0)) state_nxt = gtes_pkg::ST_READ;
      end
      gtes_pkg::ST_READ: begin
        state_nxt = gtes_pkg::ST_EMIT;
      end
      gtes_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = (rd_idx_r == CW'(fc_r - 1'b1)) ? gtes_pkg::ST_STATUS
                                                     : gtes_pkg::ST_READ;
        end
      end
      gtes_pkg::ST_STATUS: begin
        if (out_free) state_nxt = gtes_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gtes_pkg::ST_IDLE;
      end
    endcase
  end

  gtes_ram #(
    .WIDTH (66),
    .DEPTH (EVENT_SLOTS)
  ) u_event_ram (
    .clk   (clk),
    .we    (step && ev_wr),
    .waddr (held_r[AW-1:0]),
    .wdata ({ev_kind, in_if.qword_low}),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= gtes_pkg::ST_IDLE;
      scan_en_r          <= 1'b0;
      expect_payload_r   <= 1'b0;
      payload_left_r     <= '0;
      packet_format_r    <= '0;
      register_count_r   <= '0;
      descriptor_list_r  <= '0;
      descriptor_index_r <= '0;
      packet_scannable_r <= 1'b0;
      packet_path_r      <= '0;
      held_r             <= '0;
      fc_r               <= '0;
      rd_idx_r           <= '0;
      was_tag_r          <= 1'b0;
      ended_r            <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        scan_en_r <= cfg_wdata;
      end
      if (step) begin
        expect_payload_r   <= expect_payload_nxt;
        payload_left_r     <= payload_left_nxt;
        packet_format_r    <= packet_format_nxt;
        register_count_r   <= register_count_nxt;
        descriptor_list_r  <= descriptor_list_nxt;
        descriptor_index_r <= descriptor_index_nxt;
        packet_scannable_r <= packet_scannable_nxt;
        packet_path_r      <= packet_path_nxt;
        held_r             <= held_nxt;
        fc_r               <= emit_cnt;
        rd_idx_r           <= '0;
        was_tag_r          <= is_tag;
        ended_r            <= ended_nxt;
      end else if (load_event) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (load_status_now || load_status_reg || load_event) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_status_now) begin
      out_kind_r <= gtes_pkg::ITEM_STATUS;
      out_type_r <= 2'd0;
      out_data_r <= 64'd0;
      out_tag_r  <= is_tag;
      out_end_r  <= ended_nxt;
      out_pay_r  <= expect_payload_nxt;
      out_last_r <= 1'b1;
    end else if (load_status_reg) begin
      out_kind_r <= gtes_pkg::ITEM_STATUS;
      out_type_r <= 2'd0;
      out_data_r <= 64'd0;
      out_tag_r  <= was_tag_r;
      out_end_r  <= ended_r;
      out_pay_r  <= expect_payload_r;
      out_last_r <= 1'b1;
    end else if (load_event) begin
      out_kind_r <= gtes_pkg::ITEM_EVENT;
      out_type_r <= rd_data[65:64];
      out_data_r <= rd_data[63:0];
      out_tag_r  <= was_tag_r;
      out_end_r  <= ended_r;
      out_pay_r  <= expect_payload_r;
      out_last_r <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.item_kind  = out_kind_r;
  assign out_if.event_type = out_type_r;
  assign out_if.event_data = out_data_r;
  assign out_if.was_tag    = out_tag_r;
  assign out_if.packet_end = out_end_r;
  assign out_if.in_payload = out_pay_r;
  assign out_if.last       = out_last_r;

  a_held_below_slots: assert property (@(posedge clk) disable iff (!rst_n)
    held_r < SLOTS)
    else $error("event buffer count reached capacity without flush");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gtes_pkg::ST_READ || state_r == gtes_pkg::ST_EMIT) |-> (rd_idx_r < fc_r))
    else $error("event read index beyond flush count");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    expect_payload_r |-> (payload_left_r != 20'd0))
    else $error("expecting payload with nothing left");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gtes_pkg::ST_STATUS && out_free) |=> (out_valid_r && out_last_r))
    else $error("flush did not end with a status word");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gtes_pkg::ST_IDLE) |-> !in_if.ready)
    else $error("qword taken while events are draining");

endmodule

>>> verif/tb_gif_tag_event_scanner_top.sv
module tb_gif_tag_event_scanner_top;

  localparam logic [1:0] FMT_IMAGE    = 2'd2;
  localparam logic [1:0] FMT_DISABLED = 2'd3;
  localparam logic [1:0] PATH_CODE3   = 2'd3;
  localparam int         SLOTS        = gtes_pkg::EVENT_SLOTS_DEF;
  // drain wait sized for the worst flush of a full event buffer, plus margin
  localparam int         DRAIN_CYCLES = 2 * SLOTS + 8;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0]  path;
    logic        masked;
  } qword_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  etype;
    logic [63:0] data;
    logic        was_tag;
    logic        pend;
    logic        in_pl;
    logic        last;
  } scan_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  gtes_in_if  qword_bus ();
  gtes_out_if word_bus ();

  gif_tag_event_scanner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (qword_bus),
    .out_if    (word_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  qword_t     qword_q[$];
  qword_t     qword_on_bus;
  scan_word_t event_status_q[$];
  scan_word_t step_words[$];
  int         errors = 0;
  int         send_gap = 0;
  int         recv_stall = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;

  // scanner state as the block should hold it
  bit          scan_on = 1'b0;
  bit          awaiting_payload = 1'b0;
  logic [19:0] words_left = '0;
  logic [1:0]  pkt_fmt = '0;
  logic [4:0]  pkt_nregs = '0;
  logic [63:0] pkt_desc = '0;
  logic [3:0]  desc_pos = '0;
  bit          pkt_scannable = 1'b0;
  logic [1:0]  pkt_path = '0;
  int          held_count = 0;
  logic [1:0]  held_kind [SLOTS];
  logic [63:0] held_value [SLOTS];

  function automatic int unsigned pause_len(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic bit desc_has_ad(logic [63:0] list, int unsigned nregs);
    for (int i = 0; i < nregs && i < 16; i++) begin
      if (list[i*4 +: 4] == gtes_pkg::AD_DESC) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void release_held_events(logic masked);
    int n;
    n = held_count;
    held_count = 0;
    if (pkt_path == gtes_pkg::PATH3 && masked) return;
    for (int i = 0; i < n; i++)
      step_words.push_back('{gtes_pkg::ITEM_EVENT, held_kind[i], held_value[i],
                             1'b0, 1'b0, 1'b0, 1'b0});
  endfunction

  function automatic void scan_qword(qword_t q);
    bit          tag;
    bit          ended;
    int unsigned nloop;
    int unsigned nregs;
    int unsigned prod;
    int unsigned len;
    logic [3:0]  desc;
    logic [4:0]  nxt;
    logic [6:0]  addr;
    tag = 1'b0;
    ended = 1'b0;
    if (!scan_on) return;
    step_words.delete();
    if (!awaiting_payload) begin
      tag = 1'b1;
      nloop = q.lo[14:0];
      nregs = (q.lo[63:60] == 4'd0) ? gtes_pkg::NREG_MAX : q.lo[63:60];
      prod = nloop * nregs;
      pkt_fmt = q.lo[59:58];
      pkt_nregs = 5'(nregs);
      pkt_desc = q.hi;
      desc_pos = '0;
      pkt_path = q.path;
      case (pkt_fmt)
        gtes_pkg::FMT_PACKED:  len = prod;
        gtes_pkg::FMT_REGLIST: len = (prod + 1) / 2;
        default:               len = nloop;
      endcase
      words_left = len[19:0];
      pkt_scannable = (pkt_fmt == gtes_pkg::FMT_PACKED) && desc_has_ad(q.hi, nregs);
      if (words_left != 0) begin
        awaiting_payload = 1'b1;
      end else begin
        ended = 1'b1;
        release_held_events(q.masked);
      end
    end else begin
      if (pkt_scannable) begin
        desc = pkt_desc[desc_pos*4 +: 4];
        nxt = {1'b0, desc_pos} + 5'd1;
        if (nxt == pkt_nregs) nxt = '0;
        desc_pos = nxt[3:0];
        addr = q.hi[6:0];
        if (desc == gtes_pkg::AD_DESC && addr >= gtes_pkg::REG_SIGNAL
            && addr <= gtes_pkg::REG_LABEL && held_count < SLOTS) begin
          held_kind[held_count] = 2'(addr - gtes_pkg::REG_SIGNAL);
          held_value[held_count] = q.lo;
          held_count++;
          if (held_count >= SLOTS) release_held_events(q.masked);
        end
      end
      if (words_left != 0) words_left--;
      if (words_left == 0) begin
        awaiting_payload = 1'b0;
        ended = 1'b1;
        release_held_events(q.masked);
      end
    end
    step_words.push_back('{gtes_pkg::ITEM_STATUS, 2'd0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0});
    foreach (step_words[k]) begin
      step_words[k].was_tag = tag;
      step_words[k].pend = ended;
      step_words[k].in_pl = awaiting_payload;
      step_words[k].last = (k == step_words.size() - 1);
      event_status_q.push_back(step_words[k]);
    end
  endfunction

  function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // qword driver
  always @(posedge clk) begin
    if (!rst_n) begin
      qword_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (qword_bus.valid && qword_bus.ready) begin
        scan_qword(qword_on_bus);
        send_gap = pause_len(send_calm);
      end
      if (!qword_bus.valid || qword_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          qword_bus.valid <= 1'b0;
        end else if (qword_q.size() > 0) begin
          qword_on_bus = qword_q.pop_front();
          qword_bus.valid <= 1'b1;
          qword_bus.qword_low <= qword_on_bus.lo;
          qword_bus.qword_high <= qword_on_bus.hi;
          qword_bus.source_path <= qword_on_bus.path;
          qword_bus.path3_masked <= qword_on_bus.masked;
        end else begin
          qword_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    scan_word_t got;
    scan_word_t want;
    if (!rst_n) begin
      word_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (word_bus.valid && word_bus.ready) begin
        got = '{word_bus.item_kind, word_bus.event_type, word_bus.event_data, word_bus.was_tag,
                word_bus.packet_end, word_bus.in_payload, word_bus.last};
        if (event_status_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0h", $time, got);
          errors++;
        end else begin
          want = event_status_q.pop_front();
          field_check("item_kind", want.kind, got.kind);
          field_check("event_type", want.etype, got.etype);
          field_check("event_data", want.data, got.data);
          field_check("was_tag", want.was_tag, got.was_tag);
          field_check("packet_end", want.pend, got.pend);
          field_check("in_payload", want.in_pl, got.in_pl);
          field_check("last", want.last, got.last);
        end
        recv_stall = pause_len(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        word_bus.ready <= 1'b0;
      end else begin
        word_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] tag_word(logic [14:0] nloop, logic [1:0] fmt,
                                           logic [3:0] nreg_f, logic [42:0] misc);
    return {nreg_f, fmt, misc, nloop};
  endfunction

  function automatic void push_qword(logic [63:0] lo, logic [63:0] hi, logic [1:0] path,
                                     logic masked);
    qword_q.push_back('{lo, hi, path, masked});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one tag plus exactly the payload count it announces, so the block stays in step
  function automatic void add_packet(bit noisy);
    logic [1:0]  fmt;
    logic [3:0]  nreg_f;
    logic [14:0] nloop;
    logic [63:0] dl;
    logic [63:0] hi;
    logic [1:0]  path;
    int unsigned nregs;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (noisy) fmt = 2'($urandom);
    else if (pick < 65) fmt = gtes_pkg::FMT_PACKED;
    else if (pick < 80) fmt = gtes_pkg::FMT_REGLIST;
    else fmt = ($urandom_range(0, 1) == 0) ? FMT_IMAGE : FMT_DISABLED;
    nreg_f = 4'($urandom);
    nregs = (nreg_f == 4'd0) ? gtes_pkg::NREG_MAX : nreg_f;
    if ($urandom_range(0, 9) == 0) nloop = '0;
    else nloop = 15'($urandom_range(1, (fmt == gtes_pkg::FMT_PACKED) ? 3 : 6));
    if (noisy) begin
      dl = rand64();
    end else begin
      for (int i = 0; i < 16; i++)
        dl[i*4 +: 4] = ($urandom_range(0, 4) < 2) ? gtes_pkg::AD_DESC : 4'($urandom);
    end
    path = ($urandom_range(0, 9) == 0) ? PATH_CODE3 : 2'($urandom_range(0, 2));
    push_qword(tag_word(nloop, fmt, nreg_f, 43'(rand64())), dl, path, 1'($urandom));
    case (fmt)
      gtes_pkg::FMT_PACKED:  len = nloop * nregs;
      gtes_pkg::FMT_REGLIST: len = (nloop * nregs + 1) / 2;
      default:               len = nloop;
    endcase
    for (int i = 0; i < len; i++) begin
      hi = rand64();
      if (!noisy && dl[(i % nregs)*4 +: 4] == gtes_pkg::AD_DESC && $urandom_range(0, 3) != 0)
        hi[6:0] = gtes_pkg::REG_SIGNAL + 7'($urandom_range(0, 2));
      push_qword(rand64(), hi, 2'($urandom), 1'($urandom));
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (qword_q.size() != 0 || qword_bus.valid || event_status_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scan(logic on);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    scan_on = on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    qword_bus.valid = 1'b0;
    qword_bus.qword_low = '0;
    qword_bus.qword_high = '0;
    qword_bus.source_path = '0;
    qword_bus.path3_masked = 1'b0;
    word_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // scanning is off out of reset, so these are swallowed
    repeat (4) push_qword(rand64(), rand64(), 2'($urandom), 1'($urandom));
    wait_idle();
    set_scan(1'b1);

    // tag with no payload
    push_qword(tag_word(15'd0, gtes_pkg::FMT_PACKED, 4'd3, '0), 64'hEEE, 2'd0, 1'b0);
    // image format on path code 3
    push_qword(tag_word(15'd1, FMT_IMAGE, 4'd0, '1), '1, PATH_CODE3, 1'b1);
    push_qword('1, {57'd0, gtes_pkg::REG_SIGNAL}, 2'd1, 1'b0);
    // reglist, odd register count rounds up
    push_qword(tag_word(15'd1, gtes_pkg::FMT_REGLIST, 4'd3, '0), 64'h0, 2'd1, 1'b0);
    push_qword(rand64(), rand64(), 2'd0, 1'b0);
    push_qword(rand64(), rand64(), 2'd0, 1'b0);
    // all three event registers, high address bits ignored; code 3 never dropped
    push_qword(tag_word(15'd4, gtes_pkg::FMT_PACKED, 4'd1, '0), 64'hE, PATH_CODE3, 1'b1);
    push_qword('1, {57'd0, gtes_pkg::REG_SIGNAL}, 2'd0, 1'b1);
    push_qword(rand64(), {{57{1'b1}}, gtes_pkg::REG_SIGNAL + 7'd1}, 2'd0, 1'b1);
    push_qword('0, {57'd0, gtes_pkg::REG_LABEL}, 2'd0, 1'b1);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_LABEL + 7'd1}, 2'd0, 1'b1);
    // path 3 with the mask set when the events go out
    push_qword(tag_word(15'd2, gtes_pkg::FMT_PACKED, 4'd1, '0), 64'hE, gtes_pkg::PATH3, 1'b0);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_SIGNAL}, 2'd0, 1'b0);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_LABEL}, 2'd0, 1'b1);
    // path 3 masked at the tag but clear at emission
    push_qword(tag_word(15'd1, gtes_pkg::FMT_PACKED, 4'd1, '0), 64'hE, gtes_pkg::PATH3, 1'b1);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_SIGNAL + 7'd1}, 2'd0, 1'b0);
    // A+D only beyond the register count
    push_qword(tag_word(15'd1, gtes_pkg::FMT_PACKED, 4'd2, '0), 64'hE00, 2'd0, 1'b0);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_SIGNAL}, 2'd0, 1'b0);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_SIGNAL}, 2'd0, 1'b0);
    // A+D in a reglist packet is not scanned
    push_qword(tag_word(15'd1, gtes_pkg::FMT_REGLIST, 4'd1, '0), 64'hE, 2'd0, 1'b0);
    push_qword(rand64(), {57'd0, gtes_pkg::REG_SIGNAL}, 2'd0, 1'b0);

    while (qword_q.size() < 200) add_packet($urandom_range(0, 9) == 0);
    wait_idle();

    // state must survive a stretch with scanning off
    set_scan(1'b0);
    repeat (5) push_qword(rand64(), rand64(), 2'($urandom), 1'($urandom));
    wait_idle();
    set_scan(1'b1);

    while (qword_q.size() < 175) add_packet($urandom_range(0, 9) == 0);

    // longest packet: fills the event buffer mid-packet and wraps the descriptors
    push_qword(tag_word(15'h7fff, gtes_pkg::FMT_PACKED, 4'd0, '1), 64'hEEEE_EEEE_EEEE_EEEE,
               gtes_pkg::PATH3, 1'b0);
    repeat (36)
      push_qword(rand64(), {57'(rand64()), gtes_pkg::REG_SIGNAL + 7'($urandom_range(0, 2))},
                 2'($urandom), 1'($urandom));
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
